// File: design/assert_macros.svh
// Assertion helpers shared by the RTL. All checks sample on aclk and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ptp_pkg.sv
package ptp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int HALF_W    = DOT_W / 2;
    localparam int PART_W    = DOT_W + 2;
    localparam int PP_W      = 2 * DOT_W;
    localparam int NUM_W     = PP_W + 4;
    localparam int S_W       = DOT_W + DIFF_W + 3;
    localparam int SQP_W     = 35;
    localparam int SQ_W      = 2 * S_W;
    localparam int Q_W       = 32;
    localparam int DIV_W     = PP_W + Q_W + 4;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 8;
    localparam int DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_DIST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN   = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] CD_RESET = CFG_W'(655);
    localparam logic [CFG_W-1:0] BM_RESET = CFG_W'(328);

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } ptp_in_t;

    typedef struct packed {
        logic                      contact;
        logic                      degenerate;
        logic [Q_W-1:0]            distance;
        logic signed [Q_W-1:0]     weight_a;
        logic signed [Q_W-1:0]     weight_b;
        logic signed [Q_W-1:0]     weight_c;
    } ptp_out_t;

    // state of one item inside the digit pipeline
    typedef struct packed {
        logic [DIV_W-1:0] rem_a;
        logic [DIV_W-1:0] rem_b;
        logic [DIV_W-1:0] rem_c;
        logic [Q_W-1:0]   q_a;
        logic [Q_W-1:0]   q_b;
        logic [Q_W-1:0]   q_c;
        logic             neg_a;
        logic             neg_b;
        logic             neg_c;
        logic [PP_W-1:0]  det;
        logic [SQ_W-1:0]  s2;
        logic [SQ_W-1:0]  acc_p;
        logic [SQ_W-1:0]  acc_q;
        logic [Q_W-1:0]   q_s;
        logic             gate;
        logic             degen;
    } ptp_dig_t;

endpackage

// File: design/ptp_digit_pipe.sv
module ptp_digit_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  ptp_pkg::ptp_dig_t in_d,
    output logic              out_valid,
    output ptp_pkg::ptp_dig_t out_d
);
    import ptp_pkg::*;

    // one quotient / root bit per stage, MSB first
    ptp_dig_t stg_reg [Q_W];
    logic     vld_reg [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            localparam int B = Q_W - 1 - g;
            ptp_dig_t         cur;
            logic             cur_vld;
            ptp_dig_t         stg_next;
            logic [DIV_W-1:0] dsh;
            logic [SQ_W-1:0]  cand;

            if (g == 0) begin : g_first
                assign cur     = in_d;
                assign cur_vld = in_valid;
            end else begin : g_rest
                assign cur     = stg_reg[g-1];
                assign cur_vld = vld_reg[g-1];
            end

            always_comb begin
                stg_next = cur;
                dsh      = DIV_W'(cur.det) << B;
                if (cur.rem_a >= dsh) begin
                    stg_next.rem_a  = cur.rem_a - dsh;
                    stg_next.q_a[B] = 1'b1;
                end
                if (cur.rem_b >= dsh) begin
                    stg_next.rem_b  = cur.rem_b - dsh;
                    stg_next.q_b[B] = 1'b1;
                end
                if (cur.rem_c >= dsh) begin
                    stg_next.rem_c  = cur.rem_c - dsh;
                    stg_next.q_c[B] = 1'b1;
                end
                // (q + 2^B)^2 * det from running q^2*det and q*det
                cand = cur.acc_p + (cur.acc_q << (B + 1)) + (SQ_W'(cur.det) << (2 * B));
                if (cand <= cur.s2) begin
                    stg_next.acc_p  = cand;
                    stg_next.acc_q  = cur.acc_q + (SQ_W'(cur.det) << B);
                    stg_next.q_s[B] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (en) begin
                    vld_reg[g] <= cur_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    stg_reg[g] <= stg_next;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign out_d     = stg_reg[Q_W-1];

endmodule

// File: design/point_triangle_proximity_test_unit.sv
// Point versus triangle proximity test, one item per clock.
// Input channel s_valid/s_ready/s_data carries triangle a, b, c and query point p
// as signed Q15.16. Result channel m_valid/m_ready/m_data returns contact,
// degenerate, saturated distance and the three barycentric weights.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes contact_distance
// (index 0) and box_margin (index 1); cfg_ready is always high, other indexes
// are dropped. Write config only while no item is in flight.
// Pipeline: eight arithmetic stages (differences, products, dot sums, split wide
// products, determinant and numerators, squared offset), 32 digit stages that
// resolve one bit of each weight quotient and of the distance root per stage,
// and the output register.
// Throughput: one item per cycle. The whole pipe advances when the output
// register is empty or being taken; a stalled receiver freezes every stage and
// deasserts s_ready, nothing is dropped or repeated.
// Reset (synchronous, aresetn low) empties the pipe and restores
// contact_distance = 655 and box_margin = 328.
`include "assert_macros.svh"

module point_triangle_proximity_test_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ptp_pkg::ptp_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ptp_pkg::ptp_out_t                    m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ptp_pkg::DATA_W-1:0]           cfg_data
);
    import ptp_pkg::*;

    logic en;
    logic [CFG_W-1:0] cd_reg;
    logic [CFG_W-1:0] bm_reg;
    logic [8:1] vld_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_reg <= CD_RESET;
            bm_reg <= BM_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CONTACT_DIST: cd_reg <= cfg_data[CFG_W-1:0];
                REG_BOX_MARGIN:   bm_reg <= cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[7:1], s_valid};
        end
    end

    // stage 1: edge vectors and per-axis bounds
    logic signed [COORD_W-1:0] va [3], vb [3], vc [3], vp [3];
    logic signed [DIFF_W-1:0]  v0_next [3], v1_next [3], r_next [3];
    logic signed [COORD_W-1:0] lo_next [3], hi_next [3];
    logic signed [DIFF_W-1:0]  v0_reg [3], v1_reg [3], r1_reg [3];
    logic signed [COORD_W-1:0] lo_reg [3], hi_reg [3], p1_reg [3];

    assign va = '{s_data.ax, s_data.ay, s_data.az};
    assign vb = '{s_data.bx, s_data.by_coord, s_data.bz};
    assign vc = '{s_data.cx, s_data.cy, s_data.cz};
    assign vp = '{s_data.px, s_data.py, s_data.pz};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v0_next[k] = DIFF_W'(va[k]) - DIFF_W'(vc[k]);
            v1_next[k] = DIFF_W'(vb[k]) - DIFF_W'(vc[k]);
            r_next[k]  = DIFF_W'(vp[k]) - DIFF_W'(vc[k]);
            lo_next[k] = va[k];
            hi_next[k] = va[k];
            if (vb[k] < lo_next[k]) lo_next[k] = vb[k];
            if (vc[k] < lo_next[k]) lo_next[k] = vc[k];
            if (vb[k] > hi_next[k]) hi_next[k] = vb[k];
            if (vc[k] > hi_next[k]) hi_next[k] = vc[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            r1_reg <= r_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p1_reg <= vp;
        end
    end

    // stage 2: box test, coordinate products
    localparam int BOX_W = COORD_W + 2;
    logic signed [BOX_W-1:0]  p_box [3], lo_box [3], hi_box [3];
    logic                     inside_next;
    logic signed [PROD_W-1:0] dp_next [5][3], xa_next [3], xb_next [3];
    logic signed [PROD_W-1:0] dp_reg [5][3], xa_reg [3], xb_reg [3];
    logic signed [DIFF_W-1:0] r2_reg [3];
    logic                     inside2_reg;

    always_comb begin
        inside_next = 1'b1;
        for (int k = 0; k < 3; k++) begin
            p_box[k]  = BOX_W'(p1_reg[k]);
            lo_box[k] = BOX_W'(lo_reg[k]) - $signed(BOX_W'(bm_reg));
            hi_box[k] = BOX_W'(hi_reg[k]) + $signed(BOX_W'(bm_reg));
            if (p_box[k] < lo_box[k] || p_box[k] > hi_box[k]) inside_next = 1'b0;
            dp_next[0][k] = v0_reg[k] * v0_reg[k];
            dp_next[1][k] = v1_reg[k] * v1_reg[k];
            dp_next[2][k] = v0_reg[k] * v1_reg[k];
            dp_next[3][k] = v0_reg[k] * r1_reg[k];
            dp_next[4][k] = v1_reg[k] * r1_reg[k];
        end
        xa_next[0] = v0_reg[1] * v1_reg[2];
        xb_next[0] = v0_reg[2] * v1_reg[1];
        xa_next[1] = v0_reg[2] * v1_reg[0];
        xb_next[1] = v0_reg[0] * v1_reg[2];
        xa_next[2] = v0_reg[0] * v1_reg[1];
        xb_next[2] = v0_reg[1] * v1_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dp_reg      <= dp_next;
            xa_reg      <= xa_next;
            xb_reg      <= xb_next;
            r2_reg      <= r1_reg;
            inside2_reg <= inside_next;
        end
    end

    // stage 3: dot products t0..t4 and plane normal
    logic signed [DOT_W-1:0]  t_next [5], n_next [3];
    logic signed [DOT_W-1:0]  t_reg [5], n_reg [3];
    logic signed [DIFF_W-1:0] r3_reg [3];
    logic                     inside3_reg;

    always_comb begin
        for (int d = 0; d < 5; d++) begin
            t_next[d] = DOT_W'(dp_reg[d][0]) + DOT_W'(dp_reg[d][1]) + DOT_W'(dp_reg[d][2]);
        end
        for (int k = 0; k < 3; k++) begin
            n_next[k] = DOT_W'(xa_reg[k]) - DOT_W'(xb_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg       <= t_next;
            n_reg       <= n_next;
            r3_reg      <= r2_reg;
            inside3_reg <= inside2_reg;
        end
    end

    // stage 4: partial products, both operands split in halves; for s only the normal is split
    // pairs: t0*t1, t2*t2, t1*t3, t2*t4, t0*t4, t2*t3
    logic signed [DOT_W-1:0]  op_x [6], op_y [6];
    logic signed [PART_W-1:0] pll_next [6], plh_next [6], phl_next [6], phh_next [6];
    logic signed [PART_W-1:0] pll_reg [6], plh_reg [6], phl_reg [6], phh_reg [6];
    logic signed [PART_W-1:0] spl_next [3], sph_next [3], spl_reg [3], sph_reg [3];
    logic                     inside4_reg;

    always_comb begin
        op_x = '{t_reg[0], t_reg[2], t_reg[1], t_reg[2], t_reg[0], t_reg[2]};
        op_y = '{t_reg[1], t_reg[2], t_reg[3], t_reg[4], t_reg[4], t_reg[3]};
        for (int j = 0; j < 6; j++) begin
            pll_next[j] = $signed({1'b0, op_x[j][HALF_W-1:0]})
                        * $signed({1'b0, op_y[j][HALF_W-1:0]});
            plh_next[j] = $signed({1'b0, op_x[j][HALF_W-1:0]})
                        * $signed(op_y[j][DOT_W-1:HALF_W]);
            phl_next[j] = $signed(op_x[j][DOT_W-1:HALF_W])
                        * $signed({1'b0, op_y[j][HALF_W-1:0]});
            phh_next[j] = $signed(op_x[j][DOT_W-1:HALF_W])
                        * $signed(op_y[j][DOT_W-1:HALF_W]);
        end
        for (int k = 0; k < 3; k++) begin
            spl_next[k] = $signed({1'b0, n_reg[k][HALF_W-1:0]}) * r3_reg[k];
            sph_next[k] = $signed(n_reg[k][DOT_W-1:HALF_W]) * r3_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pll_reg     <= pll_next;
            plh_reg     <= plh_next;
            phl_reg     <= phl_next;
            phh_reg     <= phh_next;
            spl_reg     <= spl_next;
            sph_reg     <= sph_next;
            inside4_reg <= inside3_reg;
        end
    end

    // stage 5: full products and plane offset s
    logic signed [PP_W-1:0] pr_next [6];
    logic signed [PP_W-1:0] pr_reg [6];
    logic signed [S_W-1:0]  s_next, s5_reg;
    logic                   inside5_reg;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            pr_next[j] = (PP_W'(phh_reg[j]) <<< (2 * HALF_W))
                       + ((PP_W'(plh_reg[j]) + PP_W'(phl_reg[j])) <<< HALF_W)
                       + PP_W'(pll_reg[j]);
        end
        s_next = S_W'(spl_reg[0]) + S_W'(spl_reg[1]) + S_W'(spl_reg[2])
               + ((S_W'(sph_reg[0]) + S_W'(sph_reg[1]) + S_W'(sph_reg[2])) <<< HALF_W);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg      <= pr_next;
            s5_reg      <= s_next;
            inside5_reg <= inside4_reg;
        end
    end

    // stage 6: determinant, weight numerators, |s|
    logic signed [NUM_W-1:0] det_next, na_next, nb_next;
    logic signed [NUM_W-1:0] det6_reg, na6_reg, nb6_reg;
    logic [S_W-1:0]          sabs_next, sabs_reg;
    logic                    inside6_reg;

    always_comb begin
        det_next  = NUM_W'(pr_reg[0]) - NUM_W'(pr_reg[1]);
        na_next   = NUM_W'(pr_reg[2]) - NUM_W'(pr_reg[3]);
        nb_next   = NUM_W'(pr_reg[4]) - NUM_W'(pr_reg[5]);
        sabs_next = s5_reg[S_W-1] ? S_W'(-s5_reg) : S_W'(s5_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det6_reg    <= det_next;
            na6_reg     <= na_next;
            nb6_reg     <= nb_next;
            sabs_reg    <= sabs_next;
            inside6_reg <= inside5_reg;
        end
    end

    // stage 7: third numerator, partial squares of |s| in three slices
    logic signed [NUM_W-1:0] nc_next;
    logic signed [NUM_W-1:0] det7_reg, na7_reg, nb7_reg, nc7_reg;
    logic [SQP_W-1:0]        pa, pb, pc;
    logic [2*SQP_W-1:0]      aa_next, bb_next, cc_next, ab_next, ac_next, bc_next;
    logic [2*SQP_W-1:0]      aa_reg, bb_reg, cc_reg, ab_reg, ac_reg, bc_reg;
    logic                    inside7_reg;

    always_comb begin
        nc_next = det6_reg - na6_reg - nb6_reg;
        pa      = SQP_W'(sabs_reg[S_W-1:2*SQP_W]);
        pb      = sabs_reg[2*SQP_W-1:SQP_W];
        pc      = sabs_reg[SQP_W-1:0];
        aa_next = pa * pa;
        bb_next = pb * pb;
        cc_next = pc * pc;
        ab_next = pa * pb;
        ac_next = pa * pc;
        bc_next = pb * pc;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det7_reg    <= det6_reg;
            na7_reg     <= na6_reg;
            nb7_reg     <= nb6_reg;
            nc7_reg     <= nc_next;
            aa_reg      <= aa_next;
            bb_reg      <= bb_next;
            cc_reg      <= cc_next;
            ab_reg      <= ab_next;
            ac_reg      <= ac_next;
            bc_reg      <= bc_next;
            inside7_reg <= inside6_reg;
        end
    end

    // stage 8: s^2, range checks, dividends
    ptp_dig_t         d8_next, d8_reg;
    logic             ok_a, ok_b, ok_c;
    logic [NUM_W-1:0] abs_a, abs_b, abs_c;

    always_comb begin
        ok_a  = !na7_reg[NUM_W-1] && (na7_reg <= det7_reg);
        ok_b  = !nb7_reg[NUM_W-1] && (nb7_reg <= det7_reg);
        ok_c  = !nc7_reg[NUM_W-1] && (nc7_reg <= det7_reg);
        abs_a = na7_reg[NUM_W-1] ? NUM_W'(-na7_reg) : NUM_W'(na7_reg);
        abs_b = nb7_reg[NUM_W-1] ? NUM_W'(-nb7_reg) : NUM_W'(nb7_reg);
        abs_c = nc7_reg[NUM_W-1] ? NUM_W'(-nc7_reg) : NUM_W'(nc7_reg);
        d8_next.rem_a = DIV_W'(abs_a) << FRAC_BITS;
        d8_next.rem_b = DIV_W'(abs_b) << FRAC_BITS;
        d8_next.rem_c = DIV_W'(abs_c) << FRAC_BITS;
        d8_next.q_a   = '0;
        d8_next.q_b   = '0;
        d8_next.q_c   = '0;
        d8_next.neg_a = na7_reg[NUM_W-1];
        d8_next.neg_b = nb7_reg[NUM_W-1];
        d8_next.neg_c = nc7_reg[NUM_W-1];
        d8_next.det   = det7_reg[PP_W-1:0];
        // (a*2^70 + b*2^35 + c)^2 from the slice products
        d8_next.s2    = (SQ_W'(aa_reg) << (4 * SQP_W)) + (SQ_W'(ab_reg) << (3 * SQP_W + 1))
                      + (SQ_W'(bb_reg) << (2 * SQP_W)) + (SQ_W'(ac_reg) << (2 * SQP_W + 1))
                      + (SQ_W'(bc_reg) << (SQP_W + 1)) + SQ_W'(cc_reg);
        d8_next.acc_p = '0;
        d8_next.acc_q = '0;
        d8_next.q_s   = '0;
        d8_next.gate  = inside7_reg && ok_a && ok_b && ok_c;
        d8_next.degen = (det7_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d8_reg <= d8_next;
        end
    end

    // digit stages
    logic     dig_vld;
    ptp_dig_t dig_d;

    ptp_digit_pipe u_digits (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[8]),
        .in_d      (d8_reg),
        .out_valid (dig_vld),
        .out_d     (dig_d)
    );

    // output register
    function automatic logic [Q_W-1:0] sat_weight(input logic [Q_W-1:0] q, input logic neg);
        logic [Q_W-1:0] res;
        if (neg) begin
            res = q[Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : -q;
        end else begin
            res = q[Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}} : q;
        end
        return res;
    endfunction

    ptp_out_t out_next, out_reg;
    logic     m_valid_reg;
    logic     near;

    always_comb begin
        // |s|/sqrt(det) <= cd exactly: root below cd, or equal with zero remainder
        near = (dig_d.q_s < {1'b0, cd_reg})
            || ((dig_d.q_s == {1'b0, cd_reg}) && (dig_d.acc_p == dig_d.s2));
        out_next.degenerate = dig_d.degen;
        out_next.contact    = !dig_d.degen && dig_d.gate && near;
        if (dig_d.degen) begin
            out_next.distance = '0;
            out_next.weight_a = '0;
            out_next.weight_b = '0;
            out_next.weight_c = '0;
        end else begin
            out_next.distance = dig_d.q_s;
            out_next.weight_a = sat_weight(dig_d.q_a, dig_d.neg_a);
            out_next.weight_b = sat_weight(dig_d.q_b, dig_d.neg_b);
            out_next.weight_c = sat_weight(dig_d.q_c, dig_d.neg_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dig_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `AST_IMPL(a_degen_clean, m_valid && m_data.degenerate,
        !m_data.contact && (m_data.distance == '0), "degenerate result with contact or distance")
    `AST_IMPL(a_contact_weights, m_valid && m_data.contact,
        !m_data.weight_a[Q_W-1] && !m_data.weight_b[Q_W-1] && !m_data.weight_c[Q_W-1],
        "contact with a negative weight")
    `AST_IMPL(a_contact_dist, m_valid && m_data.contact,
        m_data.distance <= {1'b0, cd_reg}, "contact beyond contact distance")
    `AST_NEXT(a_cfg_cd, cfg_valid && cfg_ready && (cfg_index == REG_CONTACT_DIST),
        cd_reg == $past(cfg_data[CFG_W-1:0]), "contact distance write lost")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ptp_pkg::*;

    typedef logic signed [383:0] wide_t;

    localparam int  CLK_HALF   = 6;
    localparam int  PIPE_DEPTH = 41;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int  ONE = 1 << FRAC_BITS;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    ptp_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    ptp_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    // local copy of the register file
    logic [CFG_W-1:0] contact_limit;
    logic [CFG_W-1:0] margin;

    ptp_out_t pending_results[$];
    int       tx_idle_pct;
    int       rx_idle_pct;
    int       mismatches;
    longint   cycles;

    point_triangle_proximity_test_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // num * 2^FRAC_BITS / den, truncated toward zero, saturated to 32-bit signed
    function automatic logic [31:0] weight_ratio(input wide_t num, input wide_t den);
        wide_t q;
        q = ((num < 0) ? -num : num) <<< FRAC_BITS;
        q = q / den;
        if (num < 0) begin
            if (q > 64'sh8000_0000) q = 64'sh8000_0000;
            q = -q;
        end else if (q > 64'sh7FFF_FFFF) begin
            q = 64'sh7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic ptp_out_t predict_proximity(input ptp_in_t t);
        longint a[3], b[3], c[3], p[3];
        longint lo, hi, m;
        wide_t  v0[3], v1[3], r[3], n[3];
        wide_t  t0, t1, t2, t3, t4, det, na, nb, nc, s, s2, cand, cd;
        logic   in_box;
        ptp_out_t o;
        a = '{longint'(t.ax), longint'(t.ay), longint'(t.az)};
        b = '{longint'(t.bx), longint'(t.by_coord), longint'(t.bz)};
        c = '{longint'(t.cx), longint'(t.cy), longint'(t.cz)};
        p = '{longint'(t.px), longint'(t.py), longint'(t.pz)};
        m = longint'(margin);
        in_box = 1'b1;
        for (int k = 0; k < 3; k++) begin
            lo = a[k];
            hi = a[k];
            if (b[k] < lo) lo = b[k];
            if (c[k] < lo) lo = c[k];
            if (b[k] > hi) hi = b[k];
            if (c[k] > hi) hi = c[k];
            if (p[k] < lo - m || p[k] > hi + m) in_box = 1'b0;
            v0[k] = a[k] - c[k];
            v1[k] = b[k] - c[k];
            r[k]  = p[k] - c[k];
        end
        t0 = dot3(v0, v0);
        t1 = dot3(v1, v1);
        t2 = dot3(v0, v1);
        t3 = dot3(v0, r);
        t4 = dot3(v1, r);
        det = t0 * t1 - t2 * t2;
        o = '0;
        o.degenerate = (det == 0);
        if (det != 0) begin
            na = t1 * t3 - t2 * t4;
            nb = t0 * t4 - t2 * t3;
            nc = det - na - nb;
            n[0] = v0[1] * v1[2] - v0[2] * v1[1];
            n[1] = v0[2] * v1[0] - v0[0] * v1[2];
            n[2] = v0[0] * v1[1] - v0[1] * v1[0];
            s  = dot3(n, r);
            s2 = s * s;
            // largest 32-bit q with q^2 * det <= s^2
            for (int bit_i = 31; bit_i >= 0; bit_i--) begin
                cand = {352'd0, o.distance} | (wide_t'(1) <<< bit_i);
                if (cand * cand * det <= s2) o.distance = cand[31:0];
            end
            o.weight_a = weight_ratio(na, det);
            o.weight_b = weight_ratio(nb, det);
            o.weight_c = weight_ratio(nc, det);
            cd = wide_t'(contact_limit);
            o.contact = in_box && (s2 <= cd * cd * det)
                && na >= 0 && na <= det && nb >= 0 && nb <= det
                && nc >= 0 && nc <= det;
        end
        return o;
    endfunction

    function automatic ptp_in_t make_item(input longint ax, ay, az, bx, by, bz,
                                          input longint cx, cy, cz, px, py, pz);
        ptp_in_t t;
        t.ax = 32'(ax); t.ay = 32'(ay); t.az = 32'(az);
        t.bx = 32'(bx); t.by_coord = 32'(by); t.bz = 32'(bz);
        t.cx = 32'(cx); t.cy = 32'(cy); t.cz = 32'(cz);
        t.px = 32'(px); t.py = 32'(py); t.pz = 32'(pz);
        return t;
    endfunction

    // s_valid is left high after a transfer; a gap or idle_input lowers it
    task automatic send_item(input ptp_in_t t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        pending_results.insert(pending_results.size(), predict_proximity(t));
    endtask

    task automatic idle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_done();
        idle_input();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_CONTACT_DIST) contact_limit = val[CFG_W-1:0];
        else if (idx == REG_BOX_MARGIN) margin = val[CFG_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic longint rand_coord();
        return longint'($signed($urandom()));
    endfunction

    // triangle of random scale with the point near its plane, mostly over it
    function automatic ptp_in_t shaped_item();
        longint sc, a[3], b[3], c[3], p[3];
        int wa, wb, jit;
        sc  = longint'(1) << $urandom_range(2, 22);
        jit = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20000) : $urandom_range(0, 800);
        wa  = $urandom_range(0, 300) - 20;
        wb  = $urandom_range(0, 300 - ((wa > 0) ? wa : 0)) - 20;
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'($urandom_range(0, 2 * sc)) - sc;
            b[k] = longint'($urandom_range(0, 2 * sc)) - sc;
            c[k] = longint'($urandom_range(0, 2 * sc)) - sc;
            p[k] = c[k] + ((a[k] - c[k]) * wa + (b[k] - c[k]) * wb) / 256
                   + longint'($urandom_range(0, 2 * jit)) - jit;
        end
        if ($urandom_range(0, 9) == 0) b = a;
        return make_item(a[0], a[1], a[2], b[0], b[1], b[2],
                         c[0], c[1], c[2], p[0], p[1], p[2]);
    endfunction

    task automatic send_random(input int count);
        ptp_in_t t;
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                t = shaped_item();
            end else if (kind < 9) begin
                t = make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end else begin
                t = shaped_item();
                t.px = 32'(rand_coord());
            end
            send_item(t);
        end
    endtask

    // result checker and receiver stall generator
    always @(posedge aclk) begin
        ptp_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %p", m_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.contact !== exp_r.contact || m_data.degenerate !== exp_r.degenerate
                    || m_data.distance !== exp_r.distance
                    || m_data.weight_a !== exp_r.weight_a
                    || m_data.weight_b !== exp_r.weight_b
                    || m_data.weight_c !== exp_r.weight_c) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: contact %b/%b degen %b/%b dist %h/%h",
                                 exp_r.contact, m_data.contact, exp_r.degenerate,
                                 m_data.degenerate, exp_r.distance, m_data.distance);
                        $display("  weights exp %h %h %h act %h %h %h",
                                 exp_r.weight_a, exp_r.weight_b, exp_r.weight_c,
                                 m_data.weight_a, m_data.weight_b, m_data.weight_c);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        longint mx, mn, hb;
        mx = 64'sh7FFF_FFFF;
        mn = -64'sh8000_0000;
        hb = 4 * ONE + 328;
        // contact just above a small triangle, at a vertex, on an edge, then just beyond contact distance
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, ONE, ONE, 300));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, 2*ONE, 2*ONE, 0));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, ONE, ONE, 656));
        // box bounds, inclusive, then one step outside
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, hb, 0, 0));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, hb + 1, 0, 0));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, -328, -328, -328));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, -329, 0, 0));
        // degenerate: coincident and collinear vertices
        send_item(make_item(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        send_item(make_item(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0));
        send_item(make_item(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        // extremes: full-range triangle, saturated distance and weights
        send_item(make_item(mx, mn, mn, mn, mx, mn, mn, mn, mn, mx, mx, mx));
        send_item(make_item(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0, 0, mx));
        send_item(make_item(0, 0, 0, ONE, 0, 0, 0, 1, 0, mn, mx, 0));
        send_item(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mx, mx));
        send_item(make_item(mn, mx, mn, mx, mn, mx, mn, mn, mx, mn, mx, mn));
        send_item(make_item(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, -1));
        wait_results_done();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_CONTACT_DIST, 32'h0000_0000);
        write_reg(REG_BOX_MARGIN, 32'h0000_0000);
        write_reg(8'd2, 32'hFFFF_FFFF);    // out of range, dropped
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, ONE, ONE, 0));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, 4*ONE, 0, 0));
        send_item(make_item(0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, ONE, ONE, 1));
        send_random(150);
        wait_results_done();
        write_reg(REG_CONTACT_DIST, 32'hFFFF_FFFF);
        write_reg(REG_BOX_MARGIN, 32'hFFFF_FFFF);
        write_reg(8'hFF, 32'h0);
        send_random(150);
        wait_results_done();
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_reg(REG_CONTACT_DIST, $urandom_range(0, 4 * ONE));
        write_reg(REG_BOX_MARGIN, $urandom_range(0, 4 * ONE));
        send_random(count / 2);
        wait_results_done();
        write_reg(REG_CONTACT_DIST, $urandom());
        write_reg(REG_BOX_MARGIN, $urandom_range(0, 1000));
        send_random(count / 2);
        wait_results_done();
    endtask

    // sender holds off mid-stream until the pipe has emptied
    task automatic test_drain_pause();
        send_random(60);
        idle_input();
        while (pending_results.size() != 0) @(posedge aclk);
        send_random(60);
        wait_results_done();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        contact_limit = CD_RESET;
        margin        = BM_RESET;
        mismatches  = 0;
        cycles      = 0;
        tx_idle_pct = 6;
        rx_idle_pct = 71;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_config_extremes();
        test_random_phase(6, 71, 500);
        test_drain_pause();
        test_random_phase(71, 6, 500);
        test_random_phase(0, 0, 500);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/ptp_pkg.sv
design/ptp_digit_pipe.sv
design/point_triangle_proximity_test_unit.sv
sim/testbench.sv
